// File: rtl/core/csvfs_pkg.sv
// Package for the CSV field splitter: result record, codes and limits.
// Used by the parser, the result queue, the top level and the checker.
package csvfs_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int COL_W       = 9;
    localparam logic [COL_W-1:0] COL_CAP =
        (MAX_COLUMNS > 511) ? COL_W'(511) : COL_W'(MAX_COLUMNS);

    localparam logic [15:0] QUOTE_SINGLE = 16'd39;
    localparam logic [15:0] QUOTE_DOUBLE = 16'd34;
    localparam logic [15:0] SEP_RESET    = 16'd44;

    // opening quote codes
    localparam logic [1:0] OQ_NONE   = 2'd0;
    localparam logic [1:0] OQ_SINGLE = 2'd1;
    localparam logic [1:0] OQ_DOUBLE = 2'd2;

    // result kinds
    localparam logic [1:0] RK_CHAR      = 2'd0;
    localparam logic [1:0] RK_FIELD_END = 2'd1;
    localparam logic [1:0] RK_LINE_END  = 2'd2;

    // input kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP     = 8'd2;

    // result queue geometry
    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;

    typedef struct packed {
        logic [1:0]       kind;
        logic [15:0]      ch;
        logic [COL_W-1:0] col;
        logic             wrapped;
        logic             header;
    } res_t;

    typedef struct packed {
        logic one;
        logic two;
        res_t r0;
        res_t r1;
    } push_t;

endpackage

// File: rtl/core/csvfs_parser.sv
// Field splitting state machine and configuration registers.
// Depends on csvfs_pkg; produces one or two results per transfer.
module csvfs_parser
    import csvfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 take,
    input  logic                 kind,
    input  logic [15:0]          char_in,
    output push_t                push
);

    logic [15:0]      sep_reg;
    logic             hdr_reg;
    logic             strip_reg;

    logic             fhc_reg, fhc_next;
    logic [1:0]       oq_reg, oq_next;
    logic             pwq_reg, pwq_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             ofl_reg, ofl_next;

    logic [COL_W-1:0] col_inc;
    logic [15:0]      own_quote;
    logic             is_sep;
    logic             hdr_now;
    res_t             r0, r1;
    logic             two;

    assign col_inc   = (col_reg < COL_CAP) ? col_reg + COL_W'(1) : col_reg;
    assign own_quote = (oq_reg == OQ_SINGLE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
    assign is_sep    = (char_in == sep_reg);
    assign hdr_now   = hdr_reg & ofl_reg;

    always_comb
    begin
        fhc_next = fhc_reg;
        oq_next  = oq_reg;
        pwq_next = pwq_reg;
        col_next = col_reg;
        ofl_next = ofl_reg;
        two      = 1'b0;
        r0       = '{kind: RK_CHAR, ch: char_in, col: col_reg, wrapped: 1'b0,
                     header: hdr_now};
        r1       = '{kind: RK_LINE_END, ch: 16'd0, col: col_reg, wrapped: 1'b0,
                     header: hdr_now};
        if (kind == KIND_EOL)
        begin
            if (fhc_reg)
            begin
                // close the pending field, then report the line end
                two        = 1'b1;
                r0.kind    = RK_FIELD_END;
                r0.ch      = 16'd0;
                r0.wrapped = strip_reg & (oq_reg != OQ_NONE) & pwq_reg;
                r1.col     = col_inc;
            end
            else
            begin
                r0.kind = RK_LINE_END;
                r0.ch   = 16'd0;
            end
            fhc_next = 1'b0;
            oq_next  = OQ_NONE;
            pwq_next = 1'b0;
            col_next = '0;
            ofl_next = 1'b0;
        end
        else if (!fhc_reg)
        begin
            if (char_in == QUOTE_SINGLE || char_in == QUOTE_DOUBLE || !is_sep)
            begin
                if (char_in == QUOTE_SINGLE)
                    oq_next = OQ_SINGLE;
                else if (char_in == QUOTE_DOUBLE)
                    oq_next = OQ_DOUBLE;
                else
                    oq_next = OQ_NONE;
                fhc_next = 1'b1;
                pwq_next = (char_in == QUOTE_SINGLE || char_in == QUOTE_DOUBLE);
            end
            else
            begin
                // empty field
                r0.kind  = RK_FIELD_END;
                r0.ch    = 16'd0;
                col_next = col_inc;
                oq_next  = OQ_NONE;
                pwq_next = 1'b0;
            end
        end
        else if (oq_reg == OQ_NONE)
        begin
            if (is_sep)
            begin
                r0.kind  = RK_FIELD_END;
                r0.ch    = 16'd0;
                col_next = col_inc;
                fhc_next = 1'b0;
                pwq_next = 1'b0;
            end
        end
        else
        begin
            if (is_sep && pwq_reg)
            begin
                r0.kind    = RK_FIELD_END;
                r0.ch      = 16'd0;
                r0.wrapped = strip_reg;
                col_next   = col_inc;
                fhc_next   = 1'b0;
                oq_next    = OQ_NONE;
                pwq_next   = 1'b0;
            end
            else
                pwq_next = (char_in == own_quote);
        end
    end

    assign push = '{one: take, two: take & two, r0: r0, r1: r1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg   <= SEP_RESET;
            hdr_reg   <= 1'b0;
            strip_reg <= 1'b1;
            fhc_reg   <= 1'b0;
            oq_reg    <= OQ_NONE;
            pwq_reg   <= 1'b0;
            col_reg   <= '0;
            ofl_reg   <= 1'b1;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SEPARATOR: sep_reg   <= cfg_data;
                    CFG_HEADER:    hdr_reg   <= cfg_data[0];
                    CFG_STRIP:     strip_reg <= cfg_data[0];
                    default:       ;
                endcase
            end
            if (take)
            begin
                fhc_reg <= fhc_next;
                oq_reg  <= oq_next;
                pwq_reg <= pwq_next;
                col_reg <= col_next;
                ofl_reg <= ofl_next;
            end
        end
    end

endmodule

// File: rtl/core/csvfs_outq.sv
// Small result queue: takes one or two results per cycle, drains one.
// Depends on csvfs_pkg for the result record and the queue geometry.
module csvfs_outq
    import csvfs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    input  logic  pop,
    output logic  head_valid,
    output res_t  head
);

    res_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_reg, wr_next;
    logic [Q_AW-1:0] rd_reg, rd_next;
    logic [Q_AW:0]   cnt_reg, cnt_next;
    logic [Q_AW:0]   n_in;
    logic            do_pop;

    // room for a pair of results, so an end of line never overflows
    assign room       = (cnt_reg <= (Q_AW+1)'(Q_DEPTH - 2));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem[rd_reg];
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        n_in     = (Q_AW+1)'(push.one) + (Q_AW+1)'(push.two);
        wr_next  = wr_reg + n_in[Q_AW-1:0];
        rd_next  = rd_reg + Q_AW'(do_pop);
        cnt_next = cnt_reg + n_in - (Q_AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.one)
            mem[wr_reg] <= push.r0;
        if (push.two)
            mem[wr_reg + Q_AW'(1)] <= push.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/core/csv_field_splitter_top.sv
// CSV field splitter top level: parser plus result queue.
// Depends on csvfs_pkg, csvfs_parser and csvfs_outq.
//
// Input channel (in_valid/in_ready, kind, char_in) carries characters and
// end-of-line marks. Output channel (out_valid/out_ready) carries one result
// per transfer: field characters, field ends (column, quotes_wrapped) and a
// line end with the field count. Configuration writes (cfg_valid/cfg_ready,
// cfg_index, cfg_data) are always taken; unknown indexes drop.
// Each result is registered in the result queue, behind any results still waiting.
// Throughput: one input per cycle while in_ready is high; an end of line that
// closes a field makes two results and the output side drains one per cycle
// while out_ready is high, so a line that ends in a field adds one extra result
// at its end. The four-entry result queue sets this: input is taken while at
// least two entries are free. Reset empties the queue and restores the register
// defaults (separator 44, header off, strip on) and the line state. When the
// receiver stalls, the queue fills and in_ready drops; nothing is lost.
module csv_field_splitter_top
    import csvfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [15:0]          char_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           result_kind,
    output logic [15:0]          char_out,
    output logic [COL_W-1:0]     column,
    output logic                 quotes_wrapped,
    output logic                 header_line,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    push_t push;
    res_t  head;
    logic  room;

    assign in_ready  = room;
    assign cfg_ready = 1'b1;

    csvfs_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (in_valid & room),
        .kind      (kind),
        .char_in   (char_in),
        .push      (push)
    );

    csvfs_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .pop        (out_ready),
        .head_valid (out_valid),
        .head       (head)
    );

    assign result_kind    = head.kind;
    assign char_out       = head.ch;
    assign column         = head.col;
    assign quotes_wrapped = head.wrapped;
    assign header_line    = head.header;

endmodule

// File: rtl/core/csvfs_checker.sv
// Port-level checks for the CSV field splitter, bound to the top level.
// Depends on csvfs_pkg and csv_field_splitter_top.
module csvfs_checker
    import csvfs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [1:0]           result_kind,
    input logic [15:0]          char_out,
    input logic [COL_W-1:0]     column,
    input logic                 quotes_wrapped,
    input logic                 header_line
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
        && $stable(char_out) && $stable(column) && $stable(quotes_wrapped)
        && $stable(header_line))
        else $error("stalled result changed");

    // after an accepted input the output always holds a result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted input produced no result");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_kind != 2'd3)
        else $error("illegal result kind");

    a_fields_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != RK_CHAR |-> char_out == 16'd0
        && (result_kind == RK_FIELD_END || !quotes_wrapped))
        else $error("stray payload on non-character result");

    a_col_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> column <= COL_CAP)
        else $error("column beyond saturation limit");

endmodule

bind csv_field_splitter_top csvfs_checker u_csvfs_checker (.*);

// File: tb/csv_field_splitter_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for csv_field_splitter_top: a scoreboard class predicts every
// result from the accepted characters and the register settings. Depends on csvfs_pkg.

import csvfs_pkg::*;

class csv_split_board;
    // register copies
    logic [15:0]      sep;
    logic             hdr_mode;
    logic             strip_on;
    // line state
    logic             field_open;
    logic [1:0]       open_quote;
    logic             last_was_quote;
    logic [COL_W-1:0] col_idx;
    logic             first_line;
    res_t             expected_results[$];
    int               errors;
    int               checked;

    function new();
        sep            = SEP_RESET;
        hdr_mode       = 1'b0;
        strip_on       = 1'b1;
        field_open     = 1'b0;
        open_quote     = OQ_NONE;
        last_was_quote = 1'b0;
        col_idx        = '0;
        first_line     = 1'b1;
        errors         = 0;
        checked        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        case (idx)
            CFG_SEPARATOR: sep = data;
            CFG_HEADER:    hdr_mode = data[0];
            CFG_STRIP:     strip_on = data[0];
            default:       ;
        endcase
    endfunction

    function int outstanding();
        return expected_results.size();
    endfunction

    function void emit(logic [1:0] rk, logic [15:0] ch, logic w);
        res_t r;
        r.kind    = rk;
        r.ch      = ch;
        r.col     = col_idx;
        r.wrapped = w;
        r.header  = hdr_mode & first_line;
        expected_results.push_back(r);
    endfunction

    function void close_field(logic w);
        emit(RK_FIELD_END, 16'h0000, w);
        if (col_idx < COL_CAP)
            col_idx++;
        field_open     = 1'b0;
        open_quote     = OQ_NONE;
        last_was_quote = 1'b0;
    endfunction

    // Work out the results caused by one accepted input.
    function void predict(logic k, logic [15:0] c);
        if (k == KIND_EOL)
        begin
            if (field_open)
                close_field(strip_on && open_quote != OQ_NONE && last_was_quote);
            emit(RK_LINE_END, 16'h0000, 1'b0);
            col_idx        = '0;
            field_open     = 1'b0;
            open_quote     = OQ_NONE;
            last_was_quote = 1'b0;
            first_line     = 1'b0;
        end
        else if (!field_open)
        begin
            // quote test wins over the separator at field start
            if (c == QUOTE_SINGLE)
                open_quote = OQ_SINGLE;
            else if (c == QUOTE_DOUBLE)
                open_quote = OQ_DOUBLE;
            else if (c == sep)
            begin
                close_field(1'b0);
                return;
            end
            else
                open_quote = OQ_NONE;
            field_open     = 1'b1;
            last_was_quote = (open_quote != OQ_NONE);
            emit(RK_CHAR, c, 1'b0);
        end
        else if (open_quote == OQ_NONE)
        begin
            if (c == sep)
                close_field(1'b0);
            else
                emit(RK_CHAR, c, 1'b0);
        end
        else if (c == sep && last_was_quote)
            close_field(strip_on);
        else
        begin
            last_was_quote = (c == ((open_quote == OQ_SINGLE) ? QUOTE_SINGLE : QUOTE_DOUBLE));
            emit(RK_CHAR, c, 1'b0);
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 20)
            $display("MISMATCH: %s", msg);
    endtask

    task check_result(res_t got);
        res_t want;
        if (expected_results.size() == 0)
        begin
            report($sformatf("unexpected result kind %0d char %h col %0d",
                             got.kind, got.ch, got.col));
            return;
        end
        want = expected_results.pop_front();
        if (got.kind !== want.kind)
            report($sformatf("result %0d: kind %0d, expected %0d", checked, got.kind, want.kind));
        if (got.ch !== want.ch)
            report($sformatf("result %0d: char %h, expected %h", checked, got.ch, want.ch));
        if (got.col !== want.col)
            report($sformatf("result %0d: column %0d, expected %0d", checked, got.col, want.col));
        if (got.wrapped !== want.wrapped)
            report($sformatf("result %0d: quotes_wrapped %b, expected %b",
                             checked, got.wrapped, want.wrapped));
        if (got.header !== want.header)
            report($sformatf("result %0d: header_line %b, expected %b",
                             checked, got.header, want.header));
        checked++;
    endtask
endclass

module csv_field_splitter_top_test;

    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 250;
    localparam int PHASE_ITEMS   = 65;
    localparam int RANDOM_PHASES = 7;
    localparam int WIDE_FIELDS   = 262;

    // indexes outside the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 8'hFF;

    localparam logic [15:0] CH_A   = 16'd97;
    localparam logic [15:0] CH_X   = 16'd120;
    localparam logic [15:0] CH_Z   = 16'd122;
    localparam logic [15:0] CH_W   = 16'd119;
    localparam logic [15:0] CH_TAB = 16'd9;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 kind;
    logic [15:0]          char_in;
    logic                 out_valid;
    logic                 out_ready;
    logic [1:0]           result_kind;
    logic [15:0]          char_out;
    logic [COL_W-1:0]     column;
    logic                 quotes_wrapped;
    logic                 header_line;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    csv_split_board board = new();

    int   items_sent   = 0;
    int   reg_writes   = 0;
    int   stall_cycles = 0;
    logic tx_burst     = 1'b0;
    logic rx_burst     = 1'b0;
    logic rx_long_hold = 1'b0;

    csv_field_splitter_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .char_in        (char_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .char_out       (char_out),
        .column         (column),
        .quotes_wrapped (quotes_wrapped),
        .header_line    (header_line),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // End the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(input logic k, input logic [15:0] c);
        int gap;
        if ($urandom_range(0, 63) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        char_in  <= c;
        do @(posedge clk); while (!in_ready);
        board.predict(k, c);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_plain();
        logic [15:0] c;
        do
            c = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(32, 126));
        while (c == board.sep || c == QUOTE_SINGLE || c == QUOTE_DOUBLE);
        return c;
    endfunction

    function automatic logic [15:0] pick_any();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(32, 126));
            4, 5:       return board.sep;
            6:          return QUOTE_DOUBLE;
            7:          return QUOTE_SINGLE;
            default:    return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One line of fields with random content, then end of line.
    task automatic send_line();
        int          nfields;
        int          len;
        logic [15:0] q;
        nfields = $urandom_range(0, 6);
        for (int f = 0; f < nfields; f++)
        begin
            if (f > 0)
                send_item(KIND_CHAR, board.sep);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    len = $urandom_range(1, 5);
                    repeat (len) send_item(KIND_CHAR, pick_plain());
                end
                4, 5, 6, 7:
                begin
                    q   = ($urandom_range(0, 2) == 0) ? QUOTE_SINGLE : QUOTE_DOUBLE;
                    len = $urandom_range(0, 4);
                    send_item(KIND_CHAR, q);
                    repeat (len)
                        send_item(KIND_CHAR, ($urandom_range(0, 4) == 0) ? q : pick_any());
                    // leave some quoted fields open to the end of line
                    if ($urandom_range(0, 5) != 0)
                        send_item(KIND_CHAR, q);
                end
                8: ;
                default:
                begin
                    len = $urandom_range(1, 4);
                    repeat (len) send_item(KIND_CHAR, 16'($urandom_range(0, 65535)));
                end
            endcase
        end
        if ($urandom_range(0, 7) == 0)
            send_item(KIND_CHAR, board.sep);
        send_item(KIND_EOL, 16'($urandom_range(0, 65535)));
    endtask

    // A line with more fields than the column counter can count.
    task automatic send_wide_line();
        for (int i = 0; i < WIDE_FIELDS; i++)
        begin
            if (i % 16 == 0)
                send_item(KIND_CHAR, CH_W);
            send_item(KIND_CHAR, board.sep);
        end
        send_item(KIND_CHAR, CH_W);
        send_item(KIND_EOL, 16'h0000);
    endtask

    // Output side: random stalls, burst stretches and one long hold-off.
    initial
    begin
        int   wait_cycles;
        res_t got;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                rx_burst = !rx_burst;
            wait_cycles = rx_burst ? 0 : $urandom_range(0, 9);
            if (rx_long_hold)
            begin
                rx_long_hold = 1'b0;
                wait_cycles  = LONG_HOLD;
            end
            @(negedge clk);
            if (wait_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.kind    = result_kind;
            got.ch      = char_out;
            got.col     = column;
            got.wrapped = quotes_wrapped;
            got.header  = header_line;
            board.check_result(got);
        end
    end

    initial
    begin
        logic [15:0] sep_set   [RANDOM_PHASES];
        logic        hdr_set   [RANDOM_PHASES];
        logic        strip_set [RANDOM_PHASES];
        int          directed_items;
        int          phase_end;

        sep_set   = '{16'd0, 16'hFFFF, QUOTE_DOUBLE, QUOTE_SINGLE, CH_TAB,
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535))};
        hdr_set   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b0};
        strip_set = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b1};

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_CHAR;
        char_in   = 16'h0000;
        cfg_valid = 1'b0;
        cfg_index = CFG_SEPARATOR;
        cfg_data  = 16'h0000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset defaults, separator comma, strip on, header off.
        send_item(KIND_CHAR, CH_A);
        send_item(KIND_CHAR, SEP_RESET);
        send_item(KIND_CHAR, SEP_RESET);      // empty field at field start
        send_item(KIND_CHAR, QUOTE_DOUBLE);
        send_item(KIND_CHAR, CH_X);
        send_item(KIND_CHAR, QUOTE_DOUBLE);
        send_item(KIND_CHAR, SEP_RESET);      // wrapped field
        send_item(KIND_CHAR, QUOTE_SINGLE);
        send_item(KIND_CHAR, SEP_RESET);      // lone quote closes itself
        settle_block();

        // Header on while still on the first line; stray indexes must not hit a register.
        write_reg(CFG_HEADER, 16'h0001);
        write_reg(CFG_UNUSED, 16'h0000);
        write_reg(CFG_TOP, 16'h0000);
        send_item(KIND_CHAR, 16'hFFFF);
        send_item(KIND_CHAR, 16'h0000);
        send_item(KIND_CHAR, SEP_RESET);
        send_item(KIND_CHAR, QUOTE_SINGLE);
        send_item(KIND_CHAR, QUOTE_DOUBLE);   // other quote does not close
        send_item(KIND_CHAR, CH_Z);
        send_item(KIND_EOL, 16'hFFFF);        // unterminated quoted field
        send_item(KIND_EOL, 16'h0000);        // empty line
        send_item(KIND_CHAR, QUOTE_DOUBLE);
        send_item(KIND_EOL, 16'h5555);        // lone open quote at end of line
        settle_block();

        write_reg(CFG_STRIP, 16'h0000);
        write_reg(CFG_SEPARATOR, 16'h0000);
        send_item(KIND_CHAR, QUOTE_DOUBLE);
        send_item(KIND_CHAR, 16'h0000);
        send_item(KIND_CHAR, QUOTE_DOUBLE);
        send_item(KIND_EOL, 16'hAAAA);
        settle_block();
        directed_items = items_sent;

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_reg(CFG_SEPARATOR, sep_set[p]);
            write_reg(CFG_HEADER, {15'($urandom_range(0, 32767)), hdr_set[p]});
            write_reg(CFG_STRIP, {15'($urandom_range(0, 32767)), strip_set[p]});
            write_reg(CFG_TOP, 16'($urandom_range(0, 65535)));
            if (p == 2)
                rx_long_hold = 1'b1;
            if (p == 1)
                send_wide_line();
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 4) != 0)
                    send_line();
                else
                    repeat ($urandom_range(1, 8))
                        send_item(($urandom_range(0, 7) == 0) ? KIND_EOL : KIND_CHAR,
                                  pick_any());
            end
            settle_block();
        end

        repeat (8) @(posedge clk);
        $display("Covered %0d input transfers (%0d directed), %0d results, %0d register writes",
                 items_sent, directed_items, board.checked, reg_writes);
        $display("Settings included quote separators, both extremes, column saturation, long stall");
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/csvfs_pkg.sv
rtl/core/csvfs_parser.sv
rtl/core/csvfs_outq.sv
rtl/core/csv_field_splitter_top.sv
rtl/core/csvfs_checker.sv
tb/csv_field_splitter_top_test.sv
